@@ hdl/lz11hc_pkg.sv @@
// ---------------------------------------------------------------------------
// lz11hc_pkg
// Shared types and constants of the LZ11 hash-chain compressor.
// ---------------------------------------------------------------------------
package lz11hc_pkg;

   localparam int CAPACITY  = 65536;
   localparam int ADDR_W    = 16;                // store and link address
   localparam int LEN_W     = 17;                // holds 0 .. CAPACITY
   localparam int HASH_W    = 16;
   localparam int HASH_SLOTS = 65536;
   localparam int ENTRY_W   = ADDR_W + 1;        // valid bit + position
   localparam int GRP_DEPTH = 32;
   localparam int GRP_AW    = 5;

   localparam logic [LEN_W-1:0] WINDOW     = 17'h01000;
   localparam logic [LEN_W-1:0] MAX_LEN    = 17'h10110;
   localparam logic [LEN_W-1:0] MIN_LEN    = 17'd3;
   localparam logic [LEN_W-1:0] SHORT_MAX  = 17'd16;
   localparam logic [LEN_W-1:0] MID_MAX    = 17'h00110;
   localparam logic [LEN_W-1:0] MID_BASE   = 17'h00011;
   localparam logic [LEN_W-1:0] LONG_BASE  = 17'h00111;

   localparam logic [7:0] HDR_TAG         = 8'h11;
   localparam logic [7:0] LONG_TAG        = 8'h10;
   localparam logic [7:0] CHAIN_LIMIT_RST = 8'd128;

   // one result byte with its side bits
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       end_of_stream;
      logic       empty_error;
   } rsp_type;

endpackage

@@ hdl/lz11hc_ram.sv @@
// ---------------------------------------------------------------------------
// lz11hc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lz11hc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/lz11hc_out.sv @@
// ---------------------------------------------------------------------------
// lz11hc_out
// Result register: holds one result transaction until the receiver takes it.
// ---------------------------------------------------------------------------
module lz11hc_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lz11hc_pkg::rsp_type push_data,
   output logic                free,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output lz11hc_pkg::rsp_type rsp_data
);

   logic                valid_ff;
   logic                valid_in;
   lz11hc_pkg::rsp_type data_ff;

   assign free = !valid_ff || !rsp_stall;

   // load on push, drop once taken
   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff <= push_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

@@ hdl/lz11hc_core.sv @@
// ---------------------------------------------------------------------------
// lz11hc_core
// Sequencer of the compressor: loads bytes, walks hash chains with one
// byte comparator, encodes tokens into the group buffer and emits results.
// ---------------------------------------------------------------------------
module lz11hc_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_mode,
   input  logic [7:0]          req_data_byte,
   output logic                busy,
   input  logic                csr_valid,
   input  logic [7:0]          csr_data,
   input  logic                out_free,
   output logic                out_push,
   output lz11hc_pkg::rsp_type push_rsp
);

   typedef enum logic [4:0] {
      S_IDLE, S_ERR, S_CLR, S_TOK, S_HA, S_HB, S_HC, S_HD, S_HE,
      S_CCHK, S_CRD, S_CEQ, S_CEND, S_CLNK, S_TDEC, S_TENC, S_TLIT,
      S_TLITW, S_GW, S_INEXT, S_EHDR, S_EFLAG, S_EGRD, S_EGWR
   } state_type;

   localparam int AW = lz11hc_pkg::ADDR_W;
   localparam int LW = lz11hc_pkg::LEN_W;
   localparam int EW = lz11hc_pkg::ENTRY_W;

   state_type         state_ff;
   logic [LW-1:0]     len_ff;
   logic [LW-1:0]     pos_ff;
   logic              hdr_sent_ff;
   logic              send_hdr_ff;
   logic [7:0]        limit_ff;
   logic [AW-1:0]     clr_ff;
   logic [3:0]        tok_ff;
   logic [7:0]        flag_ff;
   logic [5:0]        grp_cnt_ff;
   logic [5:0]        emit_ff;
   logic [1:0]        hidx_ff;
   logic [AW-1:0]     hp_ff;
   logic              ins_mode_ff;
   logic [7:0]        b0_ff;
   logic [7:0]        b1_ff;
   logic [lz11hc_pkg::HASH_W-1:0] hash_ff;
   logic [AW-1:0]     cand_ff;
   logic              cval_ff;
   logic [7:0]        steps_ff;
   logic [LW-1:0]     best_ff;
   logic [12:0]       bdisp_ff;
   logic [LW-1:0]     disp_ff;
   logic [LW-1:0]     ml_ff;
   logic [LW-1:0]     maxl_ff;
   logic [7:0]        enc_ff [4];
   logic [2:0]        nenc_ff;
   logic [1:0]        k_ff;
   logic [LW-1:0]     ins_pos_ff;
   logic [LW-1:0]     ins_end_ff;

   // memory ports
   logic              st_we;
   logic [AW-1:0]     st_waddr;
   logic [AW-1:0]     sta_raddr;
   logic [AW-1:0]     stb_raddr;
   logic [7:0]        sta_q;
   logic [7:0]        stb_q;
   logic              hd_we;
   logic [lz11hc_pkg::HASH_W-1:0] hd_waddr;
   logic [EW-1:0]     hd_wdata;
   logic [EW-1:0]     hd_q;
   logic              lk_we;
   logic [EW-1:0]     lk_q;
   logic              gb_we;
   logic [7:0]        gb_q;
   logic [lz11hc_pkg::HASH_W-1:0] hash_c;

   logic              done_c;
   logic              req_take;
   logic [LW-1:0]     rem_c;
   logic [LW-1:0]     cdisp_c;
   logic [11:0]       d_c;
   logic [LW-1:0]     l3_c;
   logic [LW-1:0]     l4_c;

   assign done_c   = hdr_sent_ff && (pos_ff >= len_ff);
   assign req_take = req_valid && (state_ff == S_IDLE);
   assign busy     = (state_ff != S_IDLE);
   assign rem_c    = len_ff - pos_ff;
   assign cdisp_c  = pos_ff - {1'b0, cand_ff};
   assign d_c      = 12'(bdisp_ff - 13'd1);
   assign l3_c     = best_ff - lz11hc_pkg::MID_BASE;
   assign l4_c     = best_ff - lz11hc_pkg::LONG_BASE;
   assign hash_c   = {b0_ff, 8'h00} ^ {4'h0, b1_ff, 4'h0} ^ {8'h00, sta_q};

   // store write on a load transaction
   assign st_we    = req_take && !req_mode && (done_c || !hdr_sent_ff) &&
                     (done_c || (len_ff < LW'(lz11hc_pkg::CAPACITY)));
   assign st_waddr = done_c ? '0 : len_ff[AW-1:0];

   // store read addresses
   always_comb begin
      unique case (state_ff)
         S_HA:    sta_raddr = hp_ff;
         S_HB:    sta_raddr = AW'(hp_ff + AW'(1));
         S_HC:    sta_raddr = AW'(hp_ff + AW'(2));
         S_CRD:   sta_raddr = AW'(pos_ff + ml_ff);
         default: sta_raddr = pos_ff[AW-1:0];
      endcase
   end
   assign stb_raddr = AW'({1'b0, cand_ff} + ml_ff);

   // head table write: clearing pass or insertion
   always_comb begin
      hd_we    = 1'b0;
      hd_waddr = hash_ff;
      hd_wdata = {1'b1, hp_ff};
      if (state_ff == S_CLR) begin
         hd_we    = 1'b1;
         hd_waddr = clr_ff;
         hd_wdata = '0;
      end else if (state_ff == S_HE && ins_mode_ff) begin
         hd_we = 1'b1;
      end
   end
   assign lk_we = (state_ff == S_HE) && ins_mode_ff;
   assign gb_we = (state_ff == S_GW);

   lz11hc_ram #(.WIDTH(8), .DEPTH(lz11hc_pkg::CAPACITY)) u_store_a (
      .clock(clock), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(req_data_byte),
      .rd_addr(sta_raddr), .rd_data(sta_q)
   );

   lz11hc_ram #(.WIDTH(8), .DEPTH(lz11hc_pkg::CAPACITY)) u_store_b (
      .clock(clock), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(req_data_byte),
      .rd_addr(stb_raddr), .rd_data(stb_q)
   );

   lz11hc_ram #(.WIDTH(EW), .DEPTH(lz11hc_pkg::HASH_SLOTS)) u_head (
      .clock(clock), .wr_en(hd_we), .wr_addr(hd_waddr), .wr_data(hd_wdata),
      .rd_addr(hash_c), .rd_data(hd_q)
   );

   lz11hc_ram #(.WIDTH(EW), .DEPTH(lz11hc_pkg::CAPACITY)) u_link (
      .clock(clock), .wr_en(lk_we), .wr_addr(hp_ff), .wr_data(hd_q),
      .rd_addr(cand_ff), .rd_data(lk_q)
   );

   lz11hc_ram #(.WIDTH(8), .DEPTH(lz11hc_pkg::GRP_DEPTH)) u_group (
      .clock(clock), .wr_en(gb_we), .wr_addr(grp_cnt_ff[lz11hc_pkg::GRP_AW-1:0]),
      .wr_data(enc_ff[k_ff]), .rd_addr(emit_ff[lz11hc_pkg::GRP_AW-1:0]),
      .rd_data(gb_q)
   );

   // result transaction toward the output register
   always_comb begin
      out_push = 1'b0;
      push_rsp = '0;
      unique case (state_ff)
         S_ERR: begin
            out_push              = out_free;
            push_rsp.last_of_run  = 1'b1;
            push_rsp.empty_error  = 1'b1;
         end
         S_EHDR: begin
            out_push = out_free;
            unique case (hidx_ff)
               2'd0:    push_rsp.out_byte = lz11hc_pkg::HDR_TAG;
               2'd1:    push_rsp.out_byte = len_ff[7:0];
               2'd2:    push_rsp.out_byte = len_ff[15:8];
               default: push_rsp.out_byte = 8'(len_ff[LW-1:16]);
            endcase
         end
         S_EFLAG: begin
            out_push                = out_free;
            push_rsp.out_byte       = flag_ff;
            push_rsp.last_of_run    = (grp_cnt_ff == '0);
            push_rsp.end_of_stream  = (grp_cnt_ff == '0) && (pos_ff >= len_ff);
         end
         S_EGWR: begin
            out_push                = out_free;
            push_rsp.out_byte       = gb_q;
            push_rsp.last_of_run    = (emit_ff == grp_cnt_ff - 6'd1);
            push_rsp.end_of_stream  = (emit_ff == grp_cnt_ff - 6'd1) &&
                                      (pos_ff >= len_ff);
         end
         default: ;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         len_ff      <= '0;
         pos_ff      <= '0;
         hdr_sent_ff <= 1'b0;
         limit_ff    <= lz11hc_pkg::CHAIN_LIMIT_RST;
      end else begin
         if (csr_valid) begin
            limit_ff <= csr_data;
         end
         unique case (state_ff)
            S_IDLE: begin
               tok_ff     <= '0;
               flag_ff    <= '0;
               grp_cnt_ff <= '0;
               hidx_ff    <= '0;
               clr_ff     <= '0;
               if (req_valid) begin
                  if (!req_mode) begin
                     if (done_c) begin
                        len_ff      <= LW'(1);
                        pos_ff      <= '0;
                        hdr_sent_ff <= 1'b0;
                     end else if (!hdr_sent_ff &&
                                  len_ff < LW'(lz11hc_pkg::CAPACITY)) begin
                        len_ff <= len_ff + LW'(1);
                     end
                  end else if (len_ff == '0) begin
                     state_ff <= S_ERR;
                  end else if (!done_c) begin
                     send_hdr_ff <= !hdr_sent_ff;
                     if (!hdr_sent_ff) begin
                        hdr_sent_ff <= 1'b1;
                        pos_ff      <= '0;
                        state_ff    <= S_CLR;
                     end else begin
                        state_ff <= S_TOK;
                     end
                  end
               end
            end
            S_ERR: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            S_CLR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == '1) begin
                  state_ff <= S_TOK;
               end
            end
            S_TOK: begin
               best_ff <= '0;
               if (tok_ff == 4'd8 || pos_ff >= len_ff) begin
                  state_ff <= send_hdr_ff ? S_EHDR : S_EFLAG;
               end else if (pos_ff + lz11hc_pkg::MIN_LEN <= len_ff) begin
                  hp_ff       <= pos_ff[AW-1:0];
                  ins_mode_ff <= 1'b0;
                  state_ff    <= S_HA;
               end else begin
                  state_ff <= S_TLIT;
               end
            end
            S_HA: state_ff <= S_HB;
            S_HB: begin
               b0_ff    <= sta_q;
               state_ff <= S_HC;
            end
            S_HC: begin
               b1_ff    <= sta_q;
               state_ff <= S_HD;
            end
            S_HD: begin
               hash_ff  <= hash_c;
               state_ff <= S_HE;
            end
            S_HE: begin
               if (ins_mode_ff) begin
                  ins_pos_ff <= ins_pos_ff + LW'(1);
                  state_ff   <= S_INEXT;
               end else begin
                  cval_ff  <= hd_q[EW-1];
                  cand_ff  <= hd_q[AW-1:0];
                  steps_ff <= limit_ff;
                  state_ff <= S_CCHK;
               end
            end
            S_CCHK: begin
               if (!cval_ff || steps_ff == '0) begin
                  state_ff <= S_TDEC;
               end else begin
                  steps_ff <= steps_ff - 8'd1;
                  if ({1'b0, cand_ff} >= pos_ff || cdisp_c > lz11hc_pkg::WINDOW) begin
                     state_ff <= S_TDEC;
                  end else begin
                     disp_ff  <= cdisp_c;
                     ml_ff    <= '0;
                     maxl_ff  <= (rem_c > lz11hc_pkg::MAX_LEN) ?
                                 lz11hc_pkg::MAX_LEN : rem_c;
                     state_ff <= S_CRD;
                  end
               end
            end
            S_CRD: begin
               state_ff <= (ml_ff < maxl_ff) ? S_CEQ : S_CEND;
            end
            S_CEQ: begin
               if (sta_q == stb_q) begin
                  ml_ff    <= ml_ff + LW'(1);
                  state_ff <= S_CRD;
               end else begin
                  state_ff <= S_CEND;
               end
            end
            S_CEND: begin
               if (ml_ff >= lz11hc_pkg::MIN_LEN && ml_ff > best_ff) begin
                  best_ff  <= ml_ff;
                  bdisp_ff <= disp_ff[12:0];
                  state_ff <= (ml_ff >= lz11hc_pkg::MAX_LEN) ? S_TDEC : S_CLNK;
               end else begin
                  state_ff <= S_CLNK;
               end
            end
            S_CLNK: begin
               cval_ff  <= lk_q[EW-1];
               cand_ff  <= lk_q[AW-1:0];
               state_ff <= S_CCHK;
            end
            S_TDEC: begin
               state_ff <= (best_ff >= lz11hc_pkg::MIN_LEN) ? S_TENC : S_TLIT;
            end
            S_TENC: begin
               flag_ff <= flag_ff | (8'h80 >> tok_ff[2:0]);
               k_ff    <= '0;
               if (best_ff <= lz11hc_pkg::SHORT_MAX) begin
                  enc_ff[0] <= {best_ff[3:0] - 4'd1, d_c[11:8]};
                  enc_ff[1] <= d_c[7:0];
                  nenc_ff   <= 3'd2;
               end else if (best_ff <= lz11hc_pkg::MID_MAX) begin
                  enc_ff[0] <= {4'h0, l3_c[7:4]};
                  enc_ff[1] <= {l3_c[3:0], d_c[11:8]};
                  enc_ff[2] <= d_c[7:0];
                  nenc_ff   <= 3'd3;
               end else begin
                  enc_ff[0] <= lz11hc_pkg::LONG_TAG | {4'h0, l4_c[15:12]};
                  enc_ff[1] <= l4_c[11:4];
                  enc_ff[2] <= {l4_c[3:0], d_c[11:8]};
                  enc_ff[3] <= d_c[7:0];
                  nenc_ff   <= 3'd4;
               end
               state_ff <= S_GW;
            end
            S_TLIT: state_ff <= S_TLITW;
            S_TLITW: begin
               enc_ff[0] <= sta_q;
               nenc_ff   <= 3'd1;
               k_ff      <= '0;
               state_ff  <= S_GW;
            end
            S_GW: begin
               grp_cnt_ff <= grp_cnt_ff + 6'd1;
               k_ff       <= k_ff + 2'd1;
               if ({1'b0, k_ff} == nenc_ff - 3'd1) begin
                  ins_pos_ff <= pos_ff;
                  ins_end_ff <= pos_ff + ((best_ff >= lz11hc_pkg::MIN_LEN) ?
                                          best_ff : LW'(1));
                  state_ff   <= S_INEXT;
               end
            end
            S_INEXT: begin
               if (ins_pos_ff == ins_end_ff) begin
                  pos_ff   <= ins_end_ff;
                  tok_ff   <= tok_ff + 4'd1;
                  state_ff <= S_TOK;
               end else if (ins_pos_ff + lz11hc_pkg::MIN_LEN <= len_ff) begin
                  hp_ff       <= ins_pos_ff[AW-1:0];
                  ins_mode_ff <= 1'b1;
                  state_ff    <= S_HA;
               end else begin
                  ins_pos_ff <= ins_pos_ff + LW'(1);
               end
            end
            S_EHDR: begin
               if (out_free) begin
                  hidx_ff <= hidx_ff + 2'd1;
                  if (hidx_ff == 2'd3) begin
                     state_ff <= S_EFLAG;
                  end
               end
            end
            S_EFLAG: begin
               emit_ff <= '0;
               if (out_free) begin
                  state_ff <= (grp_cnt_ff == '0) ? S_IDLE : S_EGRD;
               end
            end
            S_EGRD: state_ff <= S_EGWR;
            S_EGWR: begin
               if (out_free) begin
                  emit_ff  <= emit_ff + 6'd1;
                  state_ff <= (emit_ff == grp_cnt_ff - 6'd1) ? S_IDLE : S_EGRD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

@@ hdl/lz11_hash_chain_compressor.sv @@
// ---------------------------------------------------------------------------
// lz11_hash_chain_compressor
// LZ11 stream compressor with a 3-byte hash-chain match finder.
// ---------------------------------------------------------------------------
// Usage: the req_ channel carries one transaction per item. With req_mode 0
// the byte on req_data_byte is appended to the buffer (up to 65536 bytes).
// With req_mode 1 the block emits the next group (flag byte plus up to
// eight tokens), preceded on the first group of a job by the 4-byte
// header. The first group of a job also sweeps the 65536-entry head
// table, one entry a cycle, before the search starts.
// A compress transaction takes data-dependent time: for each token, hashing,
// a compare step per compared byte and a chain step per candidate (at most
// csr chain_limit candidates), plus hashing of each inserted position, then
// the emission of each group byte. req_stall is high for that whole time;
// the shared byte comparator and the store ports set its pace.
// Results leave through the rsp_ channel one byte a transaction; a stalled
// result is held in the output register and the sequencer waits for it.
// csr_ carries chain_limit and is always ready; write it only while idle.
// Reset (synchronous) empties the buffer and sets chain_limit to 128.
// ---------------------------------------------------------------------------
module lz11_hash_chain_compressor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_mode,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   output logic       rsp_end_of_stream,
   output logic       rsp_empty_error,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   logic                busy;
   logic                out_free;
   logic                out_push;
   lz11hc_pkg::rsp_type core_rsp;
   lz11hc_pkg::rsp_type rsp_data;

   assign req_stall = busy;
   assign csr_ready = 1'b1;

   // sequencer with memories
   lz11hc_core u_core (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_mode(req_mode), .req_data_byte(req_data_byte),
      .busy(busy),
      .csr_valid(csr_valid), .csr_data(csr_data),
      .out_free(out_free), .out_push(out_push), .push_rsp(core_rsp)
   );

   // result register
   lz11hc_out u_out (
      .clock(clock), .reset(reset),
      .push(out_push), .push_data(core_rsp), .free(out_free),
      .rsp_stall(rsp_stall), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   assign rsp_out_byte      = rsp_data.out_byte;
   assign rsp_last_of_run   = rsp_data.last_of_run;
   assign rsp_end_of_stream = rsp_data.end_of_stream;
   assign rsp_empty_error   = rsp_data.empty_error;

endmodule
